@@ src/rfms_pkg.sv @@
`default_nettype none

package rfms_pkg;

  localparam int unsigned ALT_BITS       = 24;
  localparam int unsigned WINDOW_LEN_DEF = 10;
  localparam int unsigned APB_AW         = 5;
  localparam int unsigned APB_DW         = 32;
  localparam int unsigned DECIM_W        = 8;
  localparam int unsigned MAIN_WAIT_W    = 16;
  localparam int unsigned LOG_STOP_W     = 20;

  typedef enum logic [2:0] {
    MODE_STARTUP = 3'd0,
    MODE_STANDBY = 3'd1,
    MODE_ASCENT  = 3'd2,
    MODE_DROGUE  = 3'd3,
    MODE_MAIN    = 3'd4,
    MODE_FAULT   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_ALT_ARMED = 2'd1,
    EV_WAIT_DONE = 2'd2,
    EV_LOG_STOP  = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    REG_ARM_ALT     = 3'd0,
    REG_MAIN_ALT    = 3'd1,
    REG_DECIM       = 3'd2,
    REG_MAIN_WAIT   = 3'd3,
    REG_LOG_STOP    = 3'd4,
    REG_PRIOR_FAULT = 3'd5
  } reg_e;

  typedef struct packed {
    logic                       arm_key;
    logic                       launch_cmd;
    logic                       alt_valid;
    logic signed [ALT_BITS-1:0] altitude;
  } in_req_t;

  typedef struct packed {
    mode_e  mode;
    logic   mode_changed;
    logic   drogue_fire;
    logic   main_fire;
    logic   valves_open;
    logic   ref_update;
    logic   buzz;
    event_e event_res;
  } result_t;

endpackage

`default_nettype wire

@@ src/rfms_ring.sv @@
`default_nettype none

module rfms_ring #(
  parameter int unsigned DEPTH = rfms_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 we_i,
  input  wire logic [$clog2(DEPTH)-1:0]             waddr_i,
  input  wire logic signed [rfms_pkg::ALT_BITS-1:0] wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]             raddr_i,
  output logic signed [rfms_pkg::ALT_BITS-1:0]      rdata_o
);

  logic signed [rfms_pkg::ALT_BITS-1:0] mem [DEPTH];
  logic signed [rfms_pkg::ALT_BITS-1:0] rd_q;
  logic [DEPTH-1:0]                     valid_q;
  logic                                 rd_vld_q;
  logic                                 fwd;

  assign fwd = we_i && (waddr_i == raddr_i);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= fwd ? wdata_i : mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= fwd | valid_q[raddr_i];
    end
  end

  // unwritten entries read as zero
  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

@@ src/rocket_flight_mode_sequencer.sv @@
// An accepted request's result is registered into the output register, or into the skid stage
// when the output register holds a result not yet taken. One request per cycle while in_stall_o
// is low; the ring's read-modify-write reads its next slot ahead from registered memory.
// Reset: asynchronous, active low; mode startup, counters and sums cleared, ring entries read
// as zero until written, configuration at its reset values. No clearing pass is needed.
`default_nettype none

module rocket_flight_mode_sequencer #(
  parameter int unsigned WINDOW_LEN = rfms_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rfms_pkg::APB_AW-1:0]   paddr,
  input  wire logic [rfms_pkg::APB_DW-1:0]   pwdata,
  output logic [rfms_pkg::APB_DW-1:0]        prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire rfms_pkg::in_req_t             in_req_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output rfms_pkg::result_t                  out_res_o
);

  localparam int unsigned AB = rfms_pkg::ALT_BITS;
  localparam int unsigned PW = $clog2(WINDOW_LEN);
  localparam int unsigned SW = AB + PW;

  // configuration
  logic signed [AB-1:0]                  arm_alt_q;
  logic signed [AB-1:0]                  main_alt_q;
  logic [rfms_pkg::DECIM_W-1:0]          decim_int_q;
  logic [rfms_pkg::MAIN_WAIT_W-1:0]      main_wait_q;
  logic [rfms_pkg::LOG_STOP_W-1:0]       log_stop_q;
  logic                                  prior_fault_q;
  logic                                  cfg_we;
  rfms_pkg::reg_e                        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = rfms_pkg::reg_e'(paddr[rfms_pkg::APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_alt_q     <= '0;
      main_alt_q    <= '0;
      decim_int_q   <= rfms_pkg::DECIM_W'(1);
      main_wait_q   <= '0;
      log_stop_q    <= '0;
      prior_fault_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rfms_pkg::REG_ARM_ALT:     arm_alt_q     <= pwdata[AB-1:0];
        rfms_pkg::REG_MAIN_ALT:    main_alt_q    <= pwdata[AB-1:0];
        rfms_pkg::REG_DECIM:       decim_int_q   <= pwdata[rfms_pkg::DECIM_W-1:0];
        rfms_pkg::REG_MAIN_WAIT:   main_wait_q   <= pwdata[rfms_pkg::MAIN_WAIT_W-1:0];
        rfms_pkg::REG_LOG_STOP:    log_stop_q    <= pwdata[rfms_pkg::LOG_STOP_W-1:0];
        rfms_pkg::REG_PRIOR_FAULT: prior_fault_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rfms_pkg::REG_ARM_ALT:     prdata = rfms_pkg::APB_DW'(arm_alt_q);
      rfms_pkg::REG_MAIN_ALT:    prdata = rfms_pkg::APB_DW'(main_alt_q);
      rfms_pkg::REG_DECIM:       prdata = rfms_pkg::APB_DW'(decim_int_q);
      rfms_pkg::REG_MAIN_WAIT:   prdata = rfms_pkg::APB_DW'(main_wait_q);
      rfms_pkg::REG_LOG_STOP:    prdata = rfms_pkg::APB_DW'(log_stop_q);
      rfms_pkg::REG_PRIOR_FAULT: prdata = rfms_pkg::APB_DW'(prior_fault_q);
      default:                   prdata = '0;
    endcase
  end

  // flight state
  rfms_pkg::mode_e                 mode_q, mode_d;
  logic                            key_q, key_d;
  logic                            armed_q, armed_d;
  logic [PW-1:0]                   pos_q, pos_d;
  logic signed [SW-1:0]            sum_q, sum_d;
  logic [rfms_pkg::DECIM_W-1:0]    decim_q, decim_d;
  logic signed [SW-1:0]            cs0_q, cs1_q, cs2_q, cs0_d, cs1_d, cs2_d;
  logic [1:0]                      fill_q, fill_d;
  logic [rfms_pkg::MAIN_WAIT_W:0]  dticks_q, dticks_d;
  logic [rfms_pkg::LOG_STOP_W:0]   mticks_q, mticks_d;

  logic                            acc;
  logic                            ring_we;
  logic [PW-1:0]                   ring_raddr;
  logic signed [AB-1:0]            ring_old;
  logic signed [AB-1:0]            alt;

  logic go_fault, go_standby, go_startup, go_ascent, go_drogue, go_main;
  logic buzz, valves;
  logic [rfms_pkg::LOG_STOP_W:0] mt_step;
  rfms_pkg::event_e ev;

  assign alt = in_req_i.altitude;

  rfms_ring #(
    .DEPTH (WINDOW_LEN)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ring_we),
    .waddr_i (pos_q),
    .wdata_i (alt),
    .raddr_i (ring_raddr),
    .rdata_o (ring_old)
  );

  // prefetch the slot the next request will overwrite
  assign ring_raddr = acc ? pos_d : pos_q;

  always_comb begin
    key_d      = key_q;
    armed_d    = armed_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    decim_d    = decim_q;
    cs0_d      = cs0_q;
    cs1_d      = cs1_q;
    cs2_d      = cs2_q;
    fill_d     = fill_q;
    dticks_d   = dticks_q;
    mticks_d   = mticks_q;
    ring_we    = 1'b0;
    go_fault   = 1'b0;
    go_standby = 1'b0;
    go_startup = 1'b0;
    go_ascent  = 1'b0;
    go_drogue  = 1'b0;
    go_main    = 1'b0;
    buzz       = 1'b0;
    valves     = 1'b0;
    mt_step    = mticks_q;
    ev         = rfms_pkg::EV_NONE;
    unique case (mode_q)
      rfms_pkg::MODE_STARTUP: begin
        key_d      = key_q | in_req_i.arm_key;
        go_fault   = prior_fault_q;
        go_standby = !prior_fault_q && key_d;
        buzz       = go_standby && in_req_i.alt_valid;
      end
      rfms_pkg::MODE_STANDBY: begin
        key_d      = key_q & in_req_i.arm_key;
        go_ascent  = in_req_i.launch_cmd;
        go_startup = !in_req_i.launch_cmd && !key_d;
        valves     = go_ascent;
        buzz       = go_startup;
      end
      rfms_pkg::MODE_ASCENT: begin
        if (in_req_i.alt_valid && !armed_q && (alt > arm_alt_q)) begin
          armed_d = 1'b1;
          ev      = rfms_pkg::EV_ALT_ARMED;
        end
        if (in_req_i.alt_valid && armed_d) begin
          ring_we = acc;
          sum_d   = sum_q - SW'(ring_old) + SW'(alt);
          pos_d   = (pos_q == PW'(WINDOW_LEN - 1)) ? '0 : pos_q + PW'(1);
          if (decim_q == decim_int_q) begin
            cs2_d   = cs1_q;
            cs1_d   = cs0_q;
            cs0_d   = sum_d;
            fill_d  = (fill_q == 2'd3) ? fill_q : fill_q + 2'd1;
            decim_d = rfms_pkg::DECIM_W'(1);
          end else begin
            decim_d = decim_q + rfms_pkg::DECIM_W'(1);
          end
          go_drogue = (fill_d == 2'd3) && (cs2_d > cs1_d) && (cs1_d > cs0_d);
        end
      end
      rfms_pkg::MODE_DROGUE: begin
        if (dticks_q < {1'b0, main_wait_q}) begin
          dticks_d = dticks_q + 1'b1;
        end else if (dticks_q == {1'b0, main_wait_q}) begin
          ev       = rfms_pkg::EV_WAIT_DONE;
          dticks_d = dticks_q + 1'b1;
        end else begin
          go_main = alt < main_alt_q;
        end
      end
      rfms_pkg::MODE_MAIN: begin
        mt_step  = (mticks_q < {1'b0, log_stop_q}) ? mticks_q + 1'b1 : mticks_q;
        mticks_d = mt_step;
        if (mt_step == {1'b0, log_stop_q}) begin
          ev       = rfms_pkg::EV_LOG_STOP;
          mticks_d = mt_step + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mode_d = mode_q;
    unique case (mode_q)
      rfms_pkg::MODE_STARTUP: begin
        if (go_fault) begin
          mode_d = rfms_pkg::MODE_FAULT;
        end else if (go_standby) begin
          mode_d = rfms_pkg::MODE_STANDBY;
        end
      end
      rfms_pkg::MODE_STANDBY: begin
        if (go_ascent) begin
          mode_d = rfms_pkg::MODE_ASCENT;
        end else if (go_startup) begin
          mode_d = rfms_pkg::MODE_STARTUP;
        end
      end
      rfms_pkg::MODE_ASCENT: begin
        if (go_drogue) begin
          mode_d = rfms_pkg::MODE_DROGUE;
        end
      end
      rfms_pkg::MODE_DROGUE: begin
        if (go_main) begin
          mode_d = rfms_pkg::MODE_MAIN;
        end
      end
      default: ;
    endcase
  end

  rfms_pkg::result_t res;

  always_comb begin
    res.mode         = mode_d;
    res.mode_changed = mode_d != mode_q;
    res.drogue_fire  = go_drogue;
    res.main_fire    = go_main;
    res.valves_open  = valves;
    res.ref_update   = valves;
    res.buzz         = buzz;
    res.event_res    = ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= rfms_pkg::MODE_STARTUP;
      key_q    <= 1'b0;
      armed_q  <= 1'b0;
      pos_q    <= '0;
      sum_q    <= '0;
      decim_q  <= '0;
      cs0_q    <= '0;
      cs1_q    <= '0;
      cs2_q    <= '0;
      fill_q   <= '0;
      dticks_q <= '0;
      mticks_q <= '0;
    end else if (acc) begin
      mode_q   <= mode_d;
      key_q    <= key_d;
      armed_q  <= armed_d;
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      decim_q  <= decim_d;
      cs0_q    <= cs0_d;
      cs1_q    <= cs1_d;
      cs2_q    <= cs2_d;
      fill_q   <= fill_d;
      dticks_q <= dticks_d;
      mticks_q <= mticks_d;
    end
  end

  // output register with skid stage
  rfms_pkg::result_t out_q, skid_q;
  logic              out_v_q, skid_v_q;
  logic              take;

  assign in_stall_o  = skid_v_q;
  assign acc         = in_valid_i && !skid_v_q;
  assign take        = out_v_q && !out_stall_i;
  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (acc) begin
      if (out_v_q && !take) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (acc) begin
      if (out_v_q && !take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage holds a request while the output register is empty");

  a_drogue_enters_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && res.drogue_fire) |=> (mode_q == rfms_pkg::MODE_DROGUE))
    else $error("drogue fired without entering drogue mode");

  a_drogue_needs_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && res.drogue_fire) |=> (fill_q == 2'd3))
    else $error("drogue fired before three captures");

  a_ring_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < WINDOW_LEN)
    else $error("ring position out of range");

endmodule

`default_nettype wire
